FILE: rtl/chr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the cell history LED renderer.
// Used by the channel interfaces and by every renderer module; depends on nothing.
package chr_pkg;

  // Field widths of the channels.
  localparam int CELL_W      = 17;
  localparam int COLOR_W     = 8;
  localparam int FL_W        = 5;
  localparam int SLOT_W      = 8;
  localparam int TOTAL_W     = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Panel geometry, fixed by the LED buffer layout.
  localparam int LED_COLUMNS  = 8;
  localparam int LED_ROWS     = 16;
  localparam int PIXELS       = LED_COLUMNS * LED_ROWS;
  localparam int UPPER_PIXELS = PIXELS / 2;
  localparam int PIX_W        = $clog2(PIXELS);
  localparam int COL_W        = $clog2(LED_COLUMNS);
  localparam int ROW_W        = $clog2(LED_ROWS);

  // Sub-cell block size: default and the largest size the counters are built for.
  localparam int SUB_DEFAULT = 2;
  localparam int SUB_MAX     = 4;
  localparam int HIST_BITS   = 16;
  localparam int CNT_W       = $clog2(HIST_BITS + 1);
  localparam int SAND_W      = $clog2(SUB_MAX * SUB_MAX + 1);
  localparam int HIST_W      = $clog2(SUB_MAX * SUB_MAX * HIST_BITS + 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Colour scaling divider. The history of a pixel can reach 16 times the divisor
  // when the filter length is lowered inside a pixel, so the quotient is wider
  // than a colour byte and only its low byte is shown.
  localparam int QUOT_W = COLOR_W + $clog2(HIST_BITS);

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAND_RED      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAND_GREEN    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SAND_BLUE     = 2'd3;

  typedef struct packed {
    logic [FL_W-1:0]    filter_length;
    logic [COLOR_W-1:0] sand_red;
    logic [COLOR_W-1:0] sand_green;
    logic [COLOR_W-1:0] sand_blue;
  } cfg_t;

  // One classified cell, passed from the front end to the colour back end.
  typedef struct packed {
    logic [CELL_W-1:0]  new_cell;
    logic               pixel_done;
    logic [SLOT_W-1:0]  led_slot;
    logic [HIST_W-1:0]  hist;
    logic               frame_done;
    logic [TOTAL_W-1:0] upper_sand;
    logic [TOTAL_W-1:0] lower_sand;
  } item_t;

  function automatic logic [CNT_W-1:0] count_ones16(input logic [HIST_BITS-1:0] v);
    logic [HIST_BITS-1:0] s;
    begin
      s = (v & 16'h5555) + ((v >> 1) & 16'h5555);
      s = (s & 16'h3333) + ((s >> 2) & 16'h3333);
      s = (s & 16'h0F0F) + ((s >> 4) & 16'h0F0F);
      s = (s & 16'h00FF) + ((s >> 8) & 16'h00FF);
      return s[CNT_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/chr_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for cells in, results out and register writes.
// Depends on chr_pkg for field widths.
interface chr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [chr_pkg::CELL_W-1:0]   cell_value;
  modport source(output valid, output cell_value, input ready);
  modport sink(input valid, input cell_value, output ready);
endinterface

interface chr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [chr_pkg::CELL_W-1:0]   new_cell;
  logic                                pixel_done;
  logic        [chr_pkg::SLOT_W-1:0]   led_slot;
  logic        [chr_pkg::COLOR_W-1:0]  red;
  logic        [chr_pkg::COLOR_W-1:0]  green;
  logic        [chr_pkg::COLOR_W-1:0]  blue;
  logic                                frame_done;
  logic        [chr_pkg::TOTAL_W-1:0]  upper_sand;
  logic        [chr_pkg::TOTAL_W-1:0]  lower_sand;
  modport source(output valid, output new_cell, output pixel_done, output led_slot,
                 output red, output green, output blue, output frame_done,
                 output upper_sand, output lower_sand, input ready);
  modport sink(input valid, input new_cell, input pixel_done, input led_slot,
               input red, input green, input blue, input frame_done,
               input upper_sand, input lower_sand, output ready);
endinterface

interface chr_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [chr_pkg::CFG_INDEX_W-1:0]      index;
  logic [chr_pkg::CFG_DATA_W-1:0]       data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/chr_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified items between the front end and the colour back end.
// Depends on chr_pkg for the item type.
module chr_queue #(
  parameter int DEPTH = chr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  chr_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output chr_pkg::item_t pop_item,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  chr_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("item written into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("item taken from an empty queue");

endmodule

FILE: rtl/chr_front.sv
`timescale 1ns / 1ps
// Front end: takes cells, shifts their history, counts sand and history per pixel
// and per frame, and pushes one classified item per cell. Depends on chr_pkg, chr_ifs.
module chr_front #(
  parameter int SUB = chr_pkg::SUB_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  chr_in_if.sink            in_ch,
  input  chr_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              push,
  output chr_pkg::item_t    push_item
);

  localparam int CELLS     = SUB * SUB;
  localparam int SUB_IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [SUB_IDX_W-1:0]       sub_cell_index;
  logic [chr_pkg::PIX_W-1:0]  pixel_index;
  logic [chr_pkg::SAND_W-1:0] pixel_sand;
  logic [chr_pkg::HIST_W-1:0] pixel_history;
  logic [chr_pkg::TOTAL_W-1:0] upper_total;
  logic [chr_pkg::TOTAL_W-1:0] lower_total;

  logic [chr_pkg::CELL_W-1:0]    raw;
  logic                          wall;
  logic [chr_pkg::HIST_BITS-1:0] mask;
  logic [chr_pkg::CNT_W-1:0]     ones;
  logic [chr_pkg::SAND_W-1:0]    sand_now;
  logic [chr_pkg::HIST_W-1:0]    hist_now;
  logic                          pixel_end;
  logic                          frame_end;
  logic                          in_upper;
  logic [chr_pkg::TOTAL_W:0]     total_sum;
  logic [chr_pkg::TOTAL_W-1:0]   total_sat;
  logic [chr_pkg::TOTAL_W-1:0]   upper_next;
  logic [chr_pkg::TOTAL_W-1:0]   lower_next;
  logic [chr_pkg::ROW_W-1:0]     row;
  logic [chr_pkg::COL_W-1:0]     col;
  logic [chr_pkg::SLOT_W-1:0]    slot;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    raw  = $unsigned(in_ch.cell_value);
    wall = raw[chr_pkg::CELL_W-1];
    if (cfg.filter_length >= chr_pkg::FL_W'(chr_pkg::HIST_BITS)) begin
      mask = '1;
    end else begin
      mask = chr_pkg::HIST_BITS'((17'd1 << cfg.filter_length) - 17'd1);
    end
    ones     = wall ? '0 : chr_pkg::count_ones16(raw[chr_pkg::HIST_BITS-1:0] & mask);
    sand_now = pixel_sand + chr_pkg::SAND_W'(!wall && raw[0]);
    hist_now = pixel_history + chr_pkg::HIST_W'(ones);

    pixel_end = (sub_cell_index == SUB_IDX_W'(CELLS - 1));
    frame_end = pixel_end && (pixel_index == chr_pkg::PIX_W'(chr_pkg::PIXELS - 1));
    in_upper  = (pixel_index < chr_pkg::PIX_W'(chr_pkg::UPPER_PIXELS));

    total_sum = (in_upper ? {1'b0, upper_total} : {1'b0, lower_total})
              + (chr_pkg::TOTAL_W + 1)'(sand_now);
    total_sat = (total_sum > {1'b0, chr_pkg::TOTAL_MAX}) ? chr_pkg::TOTAL_MAX
              : total_sum[chr_pkg::TOTAL_W-1:0];
    upper_next = (pixel_end && in_upper) ? total_sat : upper_total;
    lower_next = (pixel_end && !in_upper) ? total_sat : lower_total;

    // Odd LED rows run right to left on the strip.
    row  = pixel_index[chr_pkg::PIX_W-1:chr_pkg::COL_W];
    col  = pixel_index[chr_pkg::COL_W-1:0];
    slot = {1'b0, row, (row[0] ? ~col : col)} + 1'b1;

    push_item.new_cell   = wall ? raw
                         : {1'b0, raw[chr_pkg::HIST_BITS-2:0], raw[0]};
    push_item.pixel_done = pixel_end;
    push_item.led_slot   = pixel_end ? slot : '0;
    push_item.hist       = hist_now;
    push_item.frame_done = frame_end;
    push_item.upper_sand = frame_end ? upper_next : '0;
    push_item.lower_sand = frame_end ? lower_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_cell_index <= '0;
      pixel_index    <= '0;
      pixel_sand     <= '0;
      pixel_history  <= '0;
      upper_total    <= '0;
      lower_total    <= '0;
    end else if (push) begin
      if (pixel_end) begin
        sub_cell_index <= '0;
        pixel_sand     <= '0;
        pixel_history  <= '0;
        if (frame_end) begin
          pixel_index <= '0;
          upper_total <= '0;
          lower_total <= '0;
        end else begin
          pixel_index <= pixel_index + 1'b1;
          upper_total <= upper_next;
          lower_total <= lower_next;
        end
      end else begin
        sub_cell_index <= sub_cell_index + 1'b1;
        pixel_sand     <= sand_now;
        pixel_history  <= hist_now;
      end
    end
  end

endmodule

FILE: rtl/chr_back.sv
`timescale 1ns / 1ps
// Back end: passes plain cells to the output register and scales the sand colour
// of each finished pixel with a bit-serial divider. Depends on chr_pkg, chr_ifs.
module chr_back #(
  parameter int SUB = chr_pkg::SUB_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  chr_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  chr_pkg::item_t q_item,
  output logic           pop,
  chr_out_if.source      out_ch
);

  localparam int CELLS  = SUB * SUB;
  localparam int DIV_W  = $clog2(CELLS * ((1 << chr_pkg::FL_W) - 1) + 1);
  localparam int REM_W  = DIV_W + chr_pkg::QUOT_W;
  localparam int STEP_W = $clog2(chr_pkg::QUOT_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  chr_pkg::item_t             job;
  logic [REM_W-1:0]           rem_r, rem_g, rem_b;
  logic [REM_W-1:0]           dsh;
  logic [chr_pkg::QUOT_W-1:0] q_r, q_g, q_b;
  logic [STEP_W-1:0]          step;
  logic                       div_zero;

  logic                       out_valid;
  chr_pkg::item_t             out_item;
  logic [chr_pkg::COLOR_W-1:0] out_red, out_green, out_blue;

  logic                       out_free;
  logic                       load_plain;
  logic                       load_pixel;
  logic [DIV_W-1:0]           divisor;
  logic                       ge_r, ge_g, ge_b;

  assign out_free   = !out_valid || out_ch.ready;
  assign load_plain = (state == S_IDLE) && !q_empty && !q_item.pixel_done && out_free;
  assign load_pixel = (state == S_OUT) && out_free;
  assign pop        = (state == S_IDLE) && !q_empty && (q_item.pixel_done || out_free);
  assign divisor    = DIV_W'(CELLS) * DIV_W'(cfg.filter_length);

  assign ge_r = (rem_r >= dsh);
  assign ge_g = (rem_g >= dsh);
  assign ge_b = (rem_b >= dsh);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (pop && q_item.pixel_done) state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (step == STEP_W'(chr_pkg::QUOT_W - 1)) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_plain || load_pixel) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Restoring division. For a non-zero divisor the product is below the divisor
  // shifted by the quotient width, so step one has the divisor at the top bit.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop && q_item.pixel_done) begin
          job <= q_item;
        end
      end
      S_MUL: begin
        rem_r    <= REM_W'(cfg.sand_red) * REM_W'(job.hist);
        rem_g    <= REM_W'(cfg.sand_green) * REM_W'(job.hist);
        rem_b    <= REM_W'(cfg.sand_blue) * REM_W'(job.hist);
        dsh      <= REM_W'(divisor) << (chr_pkg::QUOT_W - 1);
        div_zero <= (divisor == '0);
        step     <= '0;
      end
      S_DIV: begin
        if (ge_r) rem_r <= rem_r - dsh;
        if (ge_g) rem_g <= rem_g - dsh;
        if (ge_b) rem_b <= rem_b - dsh;
        q_r  <= {q_r[chr_pkg::QUOT_W-2:0], ge_r};
        q_g  <= {q_g[chr_pkg::QUOT_W-2:0], ge_g};
        q_b  <= {q_b[chr_pkg::QUOT_W-2:0], ge_b};
        dsh  <= dsh >> 1;
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_plain) begin
      out_item  <= q_item;
      out_red   <= '0;
      out_green <= '0;
      out_blue  <= '0;
    end else if (load_pixel) begin
      out_item  <= job;
      out_red   <= div_zero ? '0 : q_r[chr_pkg::COLOR_W-1:0];
      out_green <= div_zero ? '0 : q_g[chr_pkg::COLOR_W-1:0];
      out_blue  <= div_zero ? '0 : q_b[chr_pkg::COLOR_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.new_cell   = $signed(out_item.new_cell);
  assign out_ch.pixel_done = out_item.pixel_done;
  assign out_ch.led_slot   = out_item.led_slot;
  assign out_ch.red        = out_red;
  assign out_ch.green      = out_green;
  assign out_ch.blue       = out_blue;
  assign out_ch.frame_done = out_item.frame_done;
  assign out_ch.upper_sand = out_item.upper_sand;
  assign out_ch.lower_sand = out_item.lower_sand;

  a_div_length: assert property (@(posedge clk) disable iff (rst)
      (state == S_MUL) |=> (state == S_DIV) ##11 (state == S_DIV) ##1 (state == S_OUT))
    else $error("colour divide did not run its full step count");
  a_plain_blank: assert property (@(posedge clk) disable iff (rst)
      (out_ch.valid && !out_ch.pixel_done) |->
      (out_ch.led_slot == '0 && out_ch.red == '0 && out_ch.green == '0 &&
       out_ch.blue == '0))
    else $error("colour or slot shown on a cell that ends no pixel");
  a_frame_on_pixel: assert property (@(posedge clk) disable iff (rst)
      (out_ch.valid && out_ch.frame_done) |-> out_ch.pixel_done)
    else $error("frame end on a cell that ends no pixel");

endmodule

FILE: rtl/cell_history_led_renderer_top.sv
`timescale 1ns / 1ps
// Top level of the cell history LED renderer: configuration registers, front end,
// item queue and colour back end. Depends on chr_pkg, chr_ifs and the chr_ modules.
// A cell that ends no pixel passes through the queue and the output register; a
// cell that ends a pixel is popped, multiplied, divided in 12 steps, then registered.
// The back end pops no item while its one-bit-per-cycle divider runs.
// Reset (synchronous, active high) clears the counters, empties the queue and sets
// filter_length to 1 and the sand colour to full white.
module cell_history_led_renderer_top #(
  parameter int SUB         = chr_pkg::SUB_DEFAULT,
  parameter int QUEUE_DEPTH = chr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  chr_in_if.sink     in_ch,
  chr_out_if.source  out_ch,
  chr_cfg_if.sink    cfg_ch
);

  chr_pkg::cfg_t  cfg;
  logic           push;
  chr_pkg::item_t push_item;
  logic           q_full;
  logic           pop;
  chr_pkg::item_t q_item;
  logic           q_empty;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_length <= chr_pkg::FL_W'(1);
      cfg.sand_red      <= '1;
      cfg.sand_green    <= '1;
      cfg.sand_blue     <= '1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        chr_pkg::REG_FILTER_LENGTH: cfg.filter_length <= cfg_ch.data[chr_pkg::FL_W-1:0];
        chr_pkg::REG_SAND_RED:      cfg.sand_red      <= cfg_ch.data;
        chr_pkg::REG_SAND_GREEN:    cfg.sand_green    <= cfg_ch.data;
        chr_pkg::REG_SAND_BLUE:     cfg.sand_blue     <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  chr_front #(.SUB(SUB)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  chr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  chr_back #(.SUB(SUB)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
